[sv/mpc_pkg.sv]
// Package for the mains phase classifier: sequencer states, register
// indexes, operand type and the scaled timing constant table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpc_pkg;

  // Working word of the shared adder: wide enough for -175 .. +264.
  localparam int unsigned ACC_W = 10;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam logic [7:0] FREQ_50HZ = 8'd50;
  localparam logic [2:0] LOCAL_CELL = 3'd3;
  localparam logic [2:0] FLIP_BASE = 3'd6;
  localparam logic [2:0] CODE_OFFSET = 3'd3;
  localparam logic [2:0] NUM_CELLS = 3'd6;
  localparam logic [6:0] SEVEN_BITS = 7'h7f;

  typedef enum logic [1:0] {
    CFG_DATA_VALID = 2'd0,
    CFG_MAINS_FREQ = 2'd1,
    CFG_FAST_CLOCK = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEAD_CMP,
    ST_DEAD_ADD,
    ST_SUB_DELAY,
    ST_WRAP,
    ST_DIV,
    ST_ERR,
    ST_FLIP,
    ST_AG_DEC,
    ST_AG_ADD,
    ST_AG_OFF,
    ST_MOD,
    ST_INC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] ticks;
    logic [7:0] delay_norm;
    logic [7:0] delay_alt;
    logic [4:0] cell_w;
    logic [5:0] dead;
  } consts_t;

  // Base values x131/100 (truncated) when the fast clock is selected.
  function automatic consts_t mpc_consts(input logic fast, input logic sixty);
    consts_t c;
    case ({fast, sixty})
      2'b00:   c = '{ticks: 8'd98,  delay_norm: 8'd112, delay_alt: 8'd128,
                      cell_w: 5'd16, dead: 6'd45};
      2'b01:   c = '{ticks: 8'd81,  delay_norm: 8'd107, delay_alt: 8'd134,
                      cell_w: 5'd14, dead: 6'd38};
      2'b10:   c = '{ticks: 8'd128, delay_norm: 8'd146, delay_alt: 8'd167,
                      cell_w: 5'd20, dead: 6'd58};
      default: c = '{ticks: 8'd106, delay_norm: 8'd140, delay_alt: 8'd175,
                      cell_w: 5'd18, dead: 6'd49};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/mpc_alu.sv]
// Shared signed adder of the phase sequencer, with sign flag for compares.
// Depends on mpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpc_alu (
  input  mpc_pkg::acc_t a,
  input  mpc_pkg::acc_t b,
  output mpc_pkg::acc_t sum,
  output logic          neg
);
  import mpc_pkg::*;

  assign sum = a + b;
  assign neg = sum[ACC_W-1];

endmodule

`default_nettype wire

[sv/mains_phase_compute.sv]
// Mains phase classifier. One request at a time through a single shared adder.
// Result time depends on the path: a request with data unavailable goes straight
// to the result; otherwise the cell division (one subtract per cell) and the
// modulo-6 reduction (one subtract per six) take the longest.
// A new request is taken only once the last is through; a waiting result lets the next in.
// Synchronous reset clears the configuration registers to 0 and empties the output stage.
`timescale 1ns / 1ps
`default_nettype none

module mains_phase_compute (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] reading,
  input  logic       via_network,
  input  logic       alt_path,
  input  logic       agent_present,
  input  logic [7:0] agent_phase_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       status,
  output logic [2:0] phase_code,
  output logic [7:0] freq_echo,
  output logic [7:0] reading_echo,
  output logic signed [4:0] timing_error,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import mpc_pkg::*;

  // configuration registers
  logic       data_valid;
  logic [7:0] mains_freq;
  logic       fast_clock;

  state_t state, state_next;

  // working registers
  acc_t        acc, acc_next;
  logic [3:0]  quot, quot_next;
  logic [2:0]  slot, slot_next;
  logic [2:0]  code, code_next;
  logic signed [4:0] err, err_next;
  logic        use_rd, use_rd_next;
  logic        stat, stat_next;
  logic [7:0]  reading_q;
  logic        alt_q;
  logic        agent_q;
  logic [7:0]  agent_byte_q;

  consts_t k;
  logic [7:0] delay;
  acc_t alu_a, alu_b, alu_sum;
  logic alu_neg;
  logic in_fire, out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);

  assign k     = mpc_consts(fast_clock, mains_freq != FREQ_50HZ);
  assign delay = alt_q ? k.delay_alt : k.delay_norm;

  mpc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum),
    .neg (alu_neg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      mains_freq <= 8'd0;
      fast_clock <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DATA_VALID: data_valid <= cfg_data[0];
        CFG_MAINS_FREQ: mains_freq <= cfg_data;
        CFG_FAST_CLOCK: fast_clock <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!data_valid) state_next = ST_DONE;
          else if (!via_network || mains_freq == 8'd0) state_next = ST_AG_DEC;
          else state_next = ST_DEAD_CMP;
        end
      end
      ST_DEAD_CMP:  state_next = alu_neg ? ST_DEAD_ADD : ST_SUB_DELAY;
      ST_DEAD_ADD:  state_next = ST_SUB_DELAY;
      ST_SUB_DELAY: state_next = ST_WRAP;
      ST_WRAP:      if (!acc[ACC_W-1]) state_next = ST_DIV;
      ST_DIV:       if (alu_neg) state_next = ST_ERR;
      ST_ERR:       state_next = ST_FLIP;
      ST_FLIP: begin
        if (quot != 4'd0 && alu_neg) state_next = ST_DONE;
        else state_next = ST_AG_DEC;
      end
      ST_AG_DEC:    state_next = ST_AG_ADD;
      ST_AG_ADD:    state_next = ST_AG_OFF;
      ST_AG_OFF:    state_next = ST_MOD;
      ST_MOD:       if (alu_neg) state_next = ST_INC;
      ST_INC:       state_next = ST_DONE;
      ST_DONE:      if (!out_valid || out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // operand selection and working register updates
  always_comb begin
    alu_a       = acc;
    alu_b       = '0;
    acc_next    = acc;
    quot_next   = quot;
    slot_next   = slot;
    code_next   = code;
    err_next    = err;
    use_rd_next = use_rd;
    stat_next   = stat;
    unique case (state)
      ST_IDLE: begin
        acc_next    = acc_t'(reading);
        quot_next   = 4'd0;
        slot_next   = via_network ? 3'd0 : LOCAL_CELL;
        code_next   = 3'd0;
        err_next    = '0;
        use_rd_next = data_valid && via_network && (mains_freq != 8'd0);
        stat_next   = !data_valid;
      end
      ST_DEAD_CMP: alu_b = -acc_t'(k.dead);
      ST_DEAD_ADD: begin
        alu_b    = acc_t'(k.dead);
        acc_next = alu_sum;
      end
      ST_SUB_DELAY: begin
        alu_a    = acc_t'(acc[6:0] & SEVEN_BITS);
        alu_b    = -acc_t'(delay);
        acc_next = alu_sum;
      end
      ST_WRAP: begin
        alu_b = acc_t'(k.ticks);
        if (acc[ACC_W-1]) acc_next = alu_sum;
      end
      ST_DIV: begin
        alu_b = -acc_t'(k.cell_w);
        if (!alu_neg) begin
          acc_next  = alu_sum;
          quot_next = quot + 4'd1;
        end
      end
      ST_ERR: begin
        // remainder minus half the cell width
        alu_b    = -acc_t'(k.cell_w >> 1);
        err_next = alu_sum[4:0];
      end
      ST_FLIP: begin
        alu_a = acc_t'(FLIP_BASE);
        alu_b = -acc_t'(quot);
        if (quot == 4'd0) slot_next = 3'd0;
        else if (alu_neg) code_next = 3'd0;
        else slot_next = alu_sum[2:0];
      end
      ST_AG_DEC: begin
        // agent byte minus one, wrapping in 8 bits
        alu_a    = acc_t'(agent_byte_q);
        alu_b    = -acc_t'(1);
        acc_next = agent_q ? acc_t'(alu_sum[7:0]) : '0;
      end
      ST_AG_ADD: begin
        alu_b    = acc_t'(slot);
        acc_next = alu_sum;
      end
      ST_AG_OFF: begin
        alu_b    = acc_t'(CODE_OFFSET);
        acc_next = alu_sum;
      end
      ST_MOD: begin
        alu_b = -acc_t'(NUM_CELLS);
        if (!alu_neg) acc_next = alu_sum;
      end
      ST_INC: begin
        alu_b     = acc_t'(1);
        code_next = alu_sum[2:0];
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc    <= acc_next;
    quot   <= quot_next;
    slot   <= slot_next;
    code   <= code_next;
    err    <= err_next;
    use_rd <= use_rd_next;
    stat   <= stat_next;
    if (in_fire) begin
      reading_q    <= reading;
      alt_q        <= alt_path;
      agent_q      <= agent_present;
      agent_byte_q <= agent_phase_byte;
    end
    if (out_load) begin
      status       <= stat;
      phase_code   <= code;
      freq_echo    <= stat ? 8'd0 : mains_freq;
      reading_echo <= use_rd ? reading_q : 8'd0;
      timing_error <= use_rd ? err : 5'sd0;
    end
  end

endmodule

`default_nettype wire

[tb/sv/mains_phase_compute_test.sv]
// Self-checking testbench for mains_phase_compute: directed and random requests
// under several register settings, with a scoreboard class predicting every result.
// Depends on mpc_pkg and the mains_phase_compute RTL.
`timescale 1ns / 1ps

module mains_phase_compute_test;
  import mpc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 500;
  localparam int TAIL_CYCLES = 100;
  localparam int MAX_REPORTS = 40;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] reading;
    logic       via_network;
    logic       alt_path;
    logic       agent_present;
    logic [7:0] agent_byte;
  } phase_req_t;

  typedef struct packed {
    logic       status;
    logic [2:0] code;
    logic [7:0] freq;
    logic [7:0] rd;
    logic [4:0] err;
  } phase_res_t;

  class phase_scoreboard;
    logic       data_valid;
    logic [7:0] mains_freq;
    logic       fast_clock;
    phase_res_t expected_phases[$];
    int         mismatches;
    int         checked;

    function new();
      data_valid = 1'b0;
      mains_freq = 8'd0;
      fast_clock = 1'b0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        CFG_DATA_VALID: data_valid = data[0];
        CFG_MAINS_FREQ: mains_freq = data;
        CFG_FAST_CLOCK: fast_clock = data[0];
        default: ;
      endcase
    endfunction

    function int scaled(int base, int f);
      return base * f / 100;
    endfunction

    function int pending();
      return expected_phases.size();
    endfunction

    // Works out the expected result of one accepted request.
    function void note_request(phase_req_t r);
      phase_res_t e;
      int f, ticks, delay, cw, dead, v, ph, slot, err_i;
      logic sixty, ok;
      logic [7:0] agent8;
      e = '0;
      ok = 1'b1;
      slot = 0;
      if (!data_valid) begin
        e.status = 1'b1;
        expected_phases.push_back(e);
        return;
      end
      if (!r.via_network) begin
        slot = int'(LOCAL_CELL);
      end else if (mains_freq != 8'd0) begin
        sixty = (mains_freq != FREQ_50HZ);
        f = fast_clock ? 131 : 100;
        ticks = scaled(sixty ? 81 : 98, f);
        delay = scaled(r.alt_path ? (sixty ? 134 : 128) : (sixty ? 107 : 112), f);
        cw = scaled(sixty ? 14 : 16, f);
        dead = scaled(sixty ? 38 : 45, f);
        e.rd = r.reading;
        v = int'(r.reading);
        if (v < dead) v = v + dead;
        ph = (v & 'h7f) - delay;
        for (int g = 0; g < 4 && ph < 0; g++) ph = ph + ticks;
        slot = ph / cw;
        err_i = (ph % cw) - cw / 2;
        e.err = err_i[4:0];
        if (slot != 0) begin
          slot = 6 - slot;
          if (slot < 0) begin
            slot = 0;
            ok = 1'b0;
          end
        end
      end
      if (ok) begin
        agent8 = r.agent_present ? r.agent_byte - 8'd1 : 8'd0;
        slot = (slot + int'(agent8) + 3) % 6 + 1;
      end
      e.code = slot[2:0];
      e.freq = mains_freq;
      expected_phases.push_back(e);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(phase_res_t got);
      phase_res_t want;
      checked++;
      if (expected_phases.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no request waiting, expected none, got %h",
                   $time, got);
        return;
      end
      want = expected_phases.pop_front();
      compare("status", 8'(want.status), 8'(got.status));
      compare("phase_code", 8'(want.code), 8'(got.code));
      compare("freq_echo", want.freq, got.freq);
      compare("reading_echo", want.rd, got.rd);
      compare("timing_error", 8'(want.err), 8'(got.err));
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  reading = 8'd0;
  logic        via_network = 1'b0;
  logic        alt_path = 1'b0;
  logic        agent_present = 1'b0;
  logic [7:0]  agent_phase_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        status;
  logic [2:0]  phase_code;
  logic [7:0]  freq_echo;
  logic [7:0]  reading_echo;
  logic signed [4:0] timing_error;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'd0;

  phase_scoreboard sb;
  bit sender_rush = 1'b0;
  bit receiver_rush = 1'b0;
  int sent = 0;
  int settings = 0;
  int cycles = 0;

  mains_phase_compute dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .reading(reading), .via_network(via_network), .alt_path(alt_path),
    .agent_present(agent_present), .agent_phase_byte(agent_phase_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .phase_code(phase_code), .freq_echo(freq_echo),
    .reading_echo(reading_echo), .timing_error(timing_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run timed out after %0d cycles", cycles);
    $display("FAIL");
    $finish;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic phase_req_t mk(logic [7:0] rd, logic net, logic alt,
                                    logic ag_on, logic [7:0] ag);
    phase_req_t r;
    r.reading = rd;
    r.via_network = net;
    r.alt_path = alt;
    r.agent_present = ag_on;
    r.agent_byte = ag;
    return r;
  endfunction

  // Mostly network requests; half the agent bytes are well-formed phase codes.
  function automatic phase_req_t rand_req();
    return mk(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(0, 255)));
  endfunction

  task automatic offer(input phase_req_t r);
    int gap;
    gap = sender_rush ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    reading <= r.reading;
    via_network <= r.via_network;
    alt_path <= r.alt_path;
    agent_present <= r.agent_present;
    agent_phase_byte <= r.agent_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
    sent++;
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_mode(input logic dv, input logic [7:0] freq, input logic fast);
    logic [6:0] pad_a, pad_b;
    pad_a = 7'($urandom);
    pad_b = 7'($urandom);
    write_reg(CFG_DATA_VALID, {pad_a, dv});
    write_reg(CFG_MAINS_FREQ, freq);
    write_reg(CFG_FAST_CLOCK, {pad_b, fast});
    // out-of-range index must leave the registers alone
    write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) sender_rush = ($urandom_range(0, 3) == 0);
      offer(rand_req());
    end
    settle();
  endtask

  initial begin : drain
    int gap;
    wait (rst == 1'b0);
    forever begin
      if (sb.checked % 50 == 0) receiver_rush = ($urandom_range(0, 3) == 0);
      gap = receiver_rush ? 0 : pick_gap();
      // long hold-off so the block backs up and stalls its request side
      if (sb.checked == 400 || sb.checked == 1000) gap = LONG_HOLD;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result({status, phase_code, freq_echo, reading_echo, timing_error});
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // registers straight out of reset: data unavailable
    offer(mk(8'd255, 1'b1, 1'b1, 1'b1, 8'd255));
    offer(mk(8'd0, 1'b0, 1'b0, 1'b0, 8'd0));
    offer(mk(8'd128, 1'b1, 1'b0, 1'b1, 8'd1));
    settle();

    // 50 Hz, slow clock: dead zone edges, wrap edges, local requests, agent codes
    set_mode(1'b1, FREQ_50HZ, 1'b0);
    offer(mk(8'd0, 1'b1, 1'b0, 1'b0, 8'd0));
    offer(mk(8'd44, 1'b1, 1'b0, 1'b1, 8'd1));
    offer(mk(8'd45, 1'b1, 1'b1, 1'b1, 8'd6));
    offer(mk(8'd127, 1'b1, 1'b0, 1'b1, 8'd7));
    offer(mk(8'd128, 1'b1, 1'b1, 1'b0, 8'd9));
    offer(mk(8'd255, 1'b1, 1'b1, 1'b1, 8'd255));
    offer(mk(8'd200, 1'b0, 1'b0, 1'b1, 8'd0));
    offer(mk(8'd0, 1'b0, 1'b1, 1'b0, 8'd3));
    offer(mk(8'd100, 1'b1, 1'b0, 1'b1, 8'd2));
    offer(mk(8'd60, 1'b1, 1'b1, 1'b1, 8'd4));
    offer(mk(8'd112, 1'b1, 1'b0, 1'b1, 8'd3));
    offer(mk(8'd111, 1'b1, 1'b0, 1'b1, 8'd5));
    settle();

    // frequency zero skips the measurement
    set_mode(1'b1, 8'd0, 1'b0);
    offer(mk(8'd77, 1'b1, 1'b1, 1'b1, 8'd2));
    offer(mk(8'd0, 1'b0, 1'b0, 1'b1, 8'd0));
    settle();

    // 60 Hz with the fast clock: largest scaled alternate-path delay
    set_mode(1'b1, 8'd60, 1'b1);
    offer(mk(8'd0, 1'b1, 1'b1, 1'b1, 8'd1));
    offer(mk(8'd48, 1'b1, 1'b0, 1'b0, 8'd0));
    offer(mk(8'd49, 1'b1, 1'b1, 1'b1, 8'd128));
    offer(mk(8'd255, 1'b1, 1'b0, 1'b1, 8'd64));
    offer(mk(8'd174, 1'b1, 1'b0, 1'b1, 8'd6));
    settle();

    set_mode(1'b1, FREQ_50HZ, 1'b0);
    run_random(150);
    set_mode(1'b1, FREQ_50HZ, 1'b1);
    run_random(150);
    set_mode(1'b1, 8'd60, 1'b0);
    run_random(150);
    set_mode(1'b1, 8'd60, 1'b1);
    run_random(150);
    set_mode(1'b1, 8'd0, 1'b1);
    run_random(150);
    set_mode(1'b1, 8'd255, 1'b0);
    run_random(150);
    set_mode(1'b0, FREQ_50HZ, 1'b1);
    run_random(150);
    set_mode(1'b1, 8'd1, 1'b1);
    run_random(150);
    set_mode(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    run_random(150);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d requests under %0d register settings, %0d results checked",
             sent, settings, sb.checked);
    $display("Mismatches seen: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
